### hw/rtl/clcg_pkg.sv
// ============================================================================
// clcg_pkg
// Shared types, codes and arithmetic helpers for the combined LCG block.
// ============================================================================
package clcg_pkg;

    localparam logic [31:0] MOD_NARROW = 32'hFFFF_FFFF;

    localparam int CMD_W  = 3;

    localparam logic [CMD_W-1:0] CMD_GEN  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FWD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REW  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEED = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MORE = 3'd4;

    localparam int MOP_W = 4;
    localparam logic [MOP_W-1:0] MOP_G_W    = 4'd0;
    localparam logic [MOP_W-1:0] MOP_G_N    = 4'd1;
    localparam logic [MOP_W-1:0] MOP_J_WV   = 4'd2;
    localparam logic [MOP_W-1:0] MOP_J_WA   = 4'd3;
    localparam logic [MOP_W-1:0] MOP_J_WM   = 4'd4;
    localparam logic [MOP_W-1:0] MOP_J_NV   = 4'd5;
    localparam logic [MOP_W-1:0] MOP_J_NA   = 4'd6;
    localparam logic [MOP_W-1:0] MOP_J_NM   = 4'd7;
    localparam logic [MOP_W-1:0] MOP_I_ACC  = 4'd8;
    localparam logic [MOP_W-1:0] MOP_I_BASE = 4'd9;
    localparam logic [MOP_W-1:0] MOP_I_INC  = 4'd10;

    localparam int ADDR_W = 5;
    localparam logic [1:0] REG_MUL_WIDE   = 2'd0;
    localparam logic [1:0] REG_INC_WIDE   = 2'd1;
    localparam logic [1:0] REG_MUL_NARROW = 2'd2;
    localparam logic [1:0] REG_INC_NARROW = 2'd3;

    typedef struct packed {
        logic             load;
        logic             mac_start;
        logic [MOP_W-1:0] mac_op;
        logic             wshift;
        logic             nshift;
        logic             inv_cnt;
        logic             nm_from_acc;
        logic             push;
    } t_ctl;

    typedef struct packed {
        logic mac_done;
        logic wbit;
        logic wlast;
        logic nbit;
        logic nlast;
        logic mul_le1;
        logic inv_bit;
        logic inv_last;
        logic out_free;
    } t_sts;

    function automatic logic [31:0] fold1(input logic [63:0] t);
        return t[31:0] + t[63:32];
    endfunction

    function automatic logic [31:0] fold2(input logic [63:0] t);
        logic [32:0] s;
        s = {1'b0, t[31:0]} + {1'b0, t[63:32]};
        return s[31:0] + {31'd0, s[32]};
    endfunction

    function automatic logic [31:0] modred(input logic [63:0] t);
        logic [31:0] f;
        f = fold2(t);
        return (f == MOD_NARROW) ? 32'd0 : f;
    endfunction

endpackage

### hw/rtl/clcg_mac.sv
// ============================================================================
// clcg_mac
// 64-bit multiply-add mod 2^64 from three 32x32 partial products.
// ============================================================================
module clcg_mac (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    input  logic [63:0] i_y,
    input  logic [63:0] i_z,
    output logic [63:0] o_res,
    output logic        o_done
);
    logic [63:0] r_x, r_y, r_acc, r_prod;
    logic [1:0]  r_step;
    logic        r_busy, r_done;
    logic [31:0] w_a, w_b;
    logic [63:0] w_prod;

    always_comb begin
        unique case (r_step)
            2'd0:    begin w_a = r_x[31:0];  w_b = r_y[31:0];  end
            2'd1:    begin w_a = r_x[31:0];  w_b = r_y[63:32]; end
            default: begin w_a = r_x[63:32]; w_b = r_y[31:0];  end
        endcase
        w_prod = 64'(w_a) * 64'(w_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_acc <= i_z;
        end else if (r_busy) begin
            r_prod <= w_prod;
            if (r_step == 2'd1) begin
                r_acc <= r_acc + r_prod;
            end else if (r_step != 2'd0) begin
                r_acc <= r_acc + {r_prod[31:0], 32'd0};
            end
        end
    end

    assign o_res  = r_acc;
    assign o_done = r_done;
endmodule

### hw/rtl/clcg_dp.sv
// ============================================================================
// clcg_dp
// Datapath: generator state, jump registers, inverse unit and result register.
// ============================================================================
module clcg_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  clcg_pkg::t_ctl       i_ctl,
    output clcg_pkg::t_sts       o_sts,
    input  logic [2:0]           i_cmd,
    input  logic [63:0]          i_operand,
    input  logic [63:0]          i_mul_wide,
    input  logic [63:0]          i_inc_wide,
    input  logic [31:0]          i_mul_narrow,
    input  logic [31:0]          i_inc_narrow,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_rand_value
);
    logic [63:0] r_wide, r_wm, r_wa, r_wdist;
    logic [31:0] r_narrow, r_nm, r_na, r_ndist, r_ibase, r_iacc;
    logic [4:0]  r_icnt;
    logic        r_gen;
    logic [clcg_pkg::MOP_W-1:0] r_op;
    logic        r_out_valid;
    logic [31:0] r_out_data;

    logic [63:0] w_x, w_y, w_z, w_res;
    logic        w_done;

    always_comb begin
        unique case (i_ctl.mac_op)
            clcg_pkg::MOP_G_W:    begin w_x = r_wide; w_y = i_mul_wide; w_z = i_inc_wide; end
            clcg_pkg::MOP_G_N:    begin
                w_x = 64'(r_narrow); w_y = 64'(i_mul_narrow); w_z = 64'(i_inc_narrow);
            end
            clcg_pkg::MOP_J_WV:   begin w_x = r_wide; w_y = r_wm; w_z = r_wa;  end
            clcg_pkg::MOP_J_WA:   begin w_x = r_wa;   w_y = r_wm; w_z = r_wa;  end
            clcg_pkg::MOP_J_WM:   begin w_x = r_wm;   w_y = r_wm; w_z = 64'd0; end
            clcg_pkg::MOP_J_NV:   begin
                w_x = 64'(r_narrow); w_y = 64'(r_nm); w_z = 64'(r_na);
            end
            clcg_pkg::MOP_J_NA:   begin w_x = 64'(r_na); w_y = 64'(r_nm); w_z = 64'(r_na); end
            clcg_pkg::MOP_J_NM:   begin w_x = 64'(r_nm); w_y = 64'(r_nm); w_z = 64'd0; end
            clcg_pkg::MOP_I_ACC:  begin w_x = 64'(r_iacc); w_y = 64'(r_ibase); w_z = 64'd0; end
            clcg_pkg::MOP_I_BASE: begin w_x = 64'(r_ibase); w_y = 64'(r_ibase); w_z = 64'd0; end
            clcg_pkg::MOP_I_INC:  begin
                w_x = 64'(i_inc_narrow); w_y = 64'(r_nm); w_z = 64'd0;
            end
            default:              begin w_x = 64'd0; w_y = 64'd0; w_z = 64'd0; end
        endcase
    end

    clcg_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.mac_start),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_z     (w_z),
        .o_res   (w_res),
        .o_done  (w_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide   <= 64'd0;
            r_narrow <= 32'd0;
            r_gen    <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_gen <= (i_cmd == clcg_pkg::CMD_GEN) || (i_cmd == clcg_pkg::CMD_SEED)
                      || (i_cmd == clcg_pkg::CMD_MORE);
                if (i_cmd == clcg_pkg::CMD_SEED) begin
                    r_wide   <= i_operand;
                    r_narrow <= 32'd0;
                end else if (i_cmd == clcg_pkg::CMD_MORE) begin
                    r_wide   <= r_wide ^ i_operand;
                    r_narrow <= r_narrow + r_wide[63:32];
                end
            end else if (w_done) begin
                unique case (r_op)
                    clcg_pkg::MOP_G_W, clcg_pkg::MOP_J_WV: r_wide   <= w_res;
                    clcg_pkg::MOP_G_N:                     r_narrow <= clcg_pkg::fold2(w_res);
                    clcg_pkg::MOP_J_NV:                    r_narrow <= clcg_pkg::fold1(w_res);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mac_start) begin
            r_op <= i_ctl.mac_op;
        end
        if (i_ctl.load) begin
            r_wm    <= i_mul_wide;
            r_wa    <= i_inc_wide;
            r_nm    <= i_mul_narrow;
            r_na    <= i_inc_narrow;
            r_wdist <= (i_cmd == clcg_pkg::CMD_REW) ? (~i_operand + 64'd1) : i_operand;
            r_ndist <= clcg_pkg::modred(i_operand);
            r_ibase <= i_mul_narrow;
            r_iacc  <= i_mul_narrow;
            r_icnt  <= 5'd0;
        end else begin
            if (i_ctl.wshift)      r_wdist <= r_wdist >> 1;
            if (i_ctl.nshift)      r_ndist <= r_ndist >> 1;
            if (i_ctl.inv_cnt)     r_icnt  <= r_icnt + 5'd1;
            if (i_ctl.nm_from_acc) r_nm    <= r_iacc;
            if (w_done) begin
                unique case (r_op)
                    clcg_pkg::MOP_J_WA:   r_wa    <= w_res;
                    clcg_pkg::MOP_J_WM:   r_wm    <= w_res;
                    clcg_pkg::MOP_J_NA:   r_na    <= clcg_pkg::fold1(w_res);
                    clcg_pkg::MOP_J_NM:   r_nm    <= clcg_pkg::fold1(w_res);
                    clcg_pkg::MOP_I_ACC:  r_iacc  <= clcg_pkg::modred(w_res);
                    clcg_pkg::MOP_I_BASE: r_ibase <= clcg_pkg::modred(w_res);
                    clcg_pkg::MOP_I_INC:  r_na    <= ~clcg_pkg::fold1(w_res);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_out_data <= r_gen ? (r_wide[63:32] + r_narrow) : 32'd0;
        end
    end

    always_comb begin
        o_sts.mac_done = w_done;
        o_sts.wbit     = r_wdist[0];
        o_sts.wlast    = (r_wdist[63:1] == 63'd0);
        o_sts.nbit     = r_ndist[0];
        o_sts.nlast    = (r_ndist[31:1] == 31'd0);
        o_sts.mul_le1  = (i_mul_narrow[31:1] == 31'd0);
        o_sts.inv_bit  = |r_icnt[4:1];
        o_sts.inv_last = &r_icnt;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_rand_value = r_out_data;
endmodule

### hw/rtl/clcg_ctrl.sv
// ============================================================================
// clcg_ctrl
// Controller: sequences generate, jump and inverse steps on the datapath.
// ============================================================================
module clcg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [2:0]     i_cmd,
    input  clcg_pkg::t_sts i_sts,
    output clcg_pkg::t_ctl o_ctl
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_GW       = 4'd1;
    localparam logic [3:0] S_GN       = 4'd2;
    localparam logic [3:0] S_WJ_TEST  = 4'd3;
    localparam logic [3:0] S_WJ_SHIFT = 4'd4;
    localparam logic [3:0] S_WJ_M     = 4'd5;
    localparam logic [3:0] S_NJ_TEST  = 4'd6;
    localparam logic [3:0] S_NJ_SHIFT = 4'd7;
    localparam logic [3:0] S_NJ_M     = 4'd8;
    localparam logic [3:0] S_INV_INIT = 4'd9;
    localparam logic [3:0] S_INV_TEST = 4'd10;
    localparam logic [3:0] S_INV_STEP = 4'd11;
    localparam logic [3:0] S_INV_INC  = 4'd12;
    localparam logic [3:0] S_MAC_WAIT = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    logic [3:0] r_state, n_state, r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    unique case (i_cmd)
                        clcg_pkg::CMD_GEN, clcg_pkg::CMD_SEED,
                        clcg_pkg::CMD_MORE: n_state = S_GW;
                        clcg_pkg::CMD_FWD:  n_state = S_WJ_TEST;
                        clcg_pkg::CMD_REW:  n_state = S_INV_INIT;
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_GW: begin
                o_ctl.mac_start = 1'b1;
                o_ctl.mac_op    = clcg_pkg::MOP_G_W;
                n_ret           = S_GN;
                n_state         = S_MAC_WAIT;
            end
            S_GN: begin
                o_ctl.mac_start = 1'b1;
                o_ctl.mac_op    = clcg_pkg::MOP_G_N;
                n_ret           = S_DONE;
                n_state         = S_MAC_WAIT;
            end
            S_WJ_TEST: begin
                if (i_sts.wbit) begin
                    o_ctl.mac_start = 1'b1;
                    o_ctl.mac_op    = clcg_pkg::MOP_J_WV;
                    n_ret           = S_WJ_SHIFT;
                    n_state         = S_MAC_WAIT;
                end else begin
                    n_state = S_WJ_SHIFT;
                end
            end
            S_WJ_SHIFT: begin
                o_ctl.wshift = 1'b1;
                if (i_sts.wlast) begin
                    n_state = S_NJ_TEST;
                end else begin
                    o_ctl.mac_start = 1'b1;
                    o_ctl.mac_op    = clcg_pkg::MOP_J_WA;
                    n_ret           = S_WJ_M;
                    n_state         = S_MAC_WAIT;
                end
            end
            S_WJ_M: begin
                o_ctl.mac_start = 1'b1;
                o_ctl.mac_op    = clcg_pkg::MOP_J_WM;
                n_ret           = S_WJ_TEST;
                n_state         = S_MAC_WAIT;
            end
            S_NJ_TEST: begin
                if (i_sts.nbit) begin
                    o_ctl.mac_start = 1'b1;
                    o_ctl.mac_op    = clcg_pkg::MOP_J_NV;
                    n_ret           = S_NJ_SHIFT;
                    n_state         = S_MAC_WAIT;
                end else begin
                    n_state = S_NJ_SHIFT;
                end
            end
            S_NJ_SHIFT: begin
                o_ctl.nshift = 1'b1;
                if (i_sts.nlast) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.mac_start = 1'b1;
                    o_ctl.mac_op    = clcg_pkg::MOP_J_NA;
                    n_ret           = S_NJ_M;
                    n_state         = S_MAC_WAIT;
                end
            end
            S_NJ_M: begin
                o_ctl.mac_start = 1'b1;
                o_ctl.mac_op    = clcg_pkg::MOP_J_NM;
                n_ret           = S_NJ_TEST;
                n_state         = S_MAC_WAIT;
            end
            S_INV_INIT: begin
                n_state = i_sts.mul_le1 ? S_INV_INC : S_INV_TEST;
            end
            S_INV_TEST: begin
                if (i_sts.inv_bit) begin
                    o_ctl.mac_start = 1'b1;
                    o_ctl.mac_op    = clcg_pkg::MOP_I_ACC;
                    n_ret           = S_INV_STEP;
                    n_state         = S_MAC_WAIT;
                end else begin
                    n_state = S_INV_STEP;
                end
            end
            S_INV_STEP: begin
                if (i_sts.inv_last) begin
                    o_ctl.nm_from_acc = 1'b1;
                    n_state           = S_INV_INC;
                end else begin
                    o_ctl.inv_cnt   = 1'b1;
                    o_ctl.mac_start = 1'b1;
                    o_ctl.mac_op    = clcg_pkg::MOP_I_BASE;
                    n_ret           = S_INV_TEST;
                    n_state         = S_MAC_WAIT;
                end
            end
            S_INV_INC: begin
                o_ctl.mac_start = 1'b1;
                o_ctl.mac_op    = clcg_pkg::MOP_I_INC;
                n_ret           = S_WJ_TEST;
                n_state         = S_MAC_WAIT;
            end
            S_MAC_WAIT: begin
                if (i_sts.mac_done) begin
                    n_state = r_ret;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

### hw/rtl/combined_lcg_rng_with_jump_top.sv
// ============================================================================
// combined_lcg_rng_with_jump_top
// Combined 64-bit / mod 2^32-1 LCG with jump ahead, rewind and seeding.
//
//  channel  dir  handshake                      payload
//  input    in   i_in_valid / o_in_ready        i_cmd, i_operand
//  result   out  o_out_valid / i_out_ready      o_rand_value
//  config   in   psel penable pwrite pready     paddr, pwdata, prdata
//
//  Every multiply goes through one shared 32x32 multiply-add unit. Jumps
//  step through the distance bits (up to 64 + 32 bits); rewind first computes
//  the inverse multiplier. Synchronous active-low reset clears the generator
//  state, controller state, config registers and result valid flag. A full
//  result register holds the item in its final state until it is taken.
// ============================================================================
module combined_lcg_rng_with_jump_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_cmd,
    input  logic [63:0]                  i_operand,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [31:0]                  o_rand_value,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [clcg_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready
);
    logic [63:0] r_mul_wide, r_inc_wide;
    logic [31:0] r_mul_narrow, r_inc_narrow;
    logic        w_wr;
    clcg_pkg::t_ctl w_ctl;
    clcg_pkg::t_sts w_sts;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_wide   <= 64'd0;
            r_inc_wide   <= 64'd0;
            r_mul_narrow <= 32'd0;
            r_inc_narrow <= 32'd0;
        end else if (w_wr) begin
            unique case (paddr[4:3])
                clcg_pkg::REG_MUL_WIDE:   r_mul_wide   <= pwdata;
                clcg_pkg::REG_INC_WIDE:   r_inc_wide   <= pwdata;
                clcg_pkg::REG_MUL_NARROW: r_mul_narrow <= pwdata[31:0];
                clcg_pkg::REG_INC_NARROW: r_inc_narrow <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            clcg_pkg::REG_MUL_WIDE:   prdata = r_mul_wide;
            clcg_pkg::REG_INC_WIDE:   prdata = r_inc_wide;
            clcg_pkg::REG_MUL_NARROW: prdata = 64'(r_mul_narrow);
            clcg_pkg::REG_INC_NARROW: prdata = 64'(r_inc_narrow);
            default:                  prdata = 64'd0;
        endcase
    end

    clcg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cmd      (i_cmd),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    clcg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_sts        (w_sts),
        .i_cmd        (i_cmd),
        .i_operand    (i_operand),
        .i_mul_wide   (r_mul_wide),
        .i_inc_wide   (r_inc_wide),
        .i_mul_narrow (r_mul_narrow),
        .i_inc_narrow (r_inc_narrow),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_rand_value (o_rand_value)
    );
endmodule
